>>> sv/pure_pursuit_steering_defines.svh
// Assertion macros shared by the pure pursuit steering RTL.
// No dependencies; included by modules that carry assertions.
`ifndef PURE_PURSUIT_STEERING_DEFINES_SVH
`define PURE_PURSUIT_STEERING_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication
`define PPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pps: same-cycle check failed");
// Next-cycle implication
`define PPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pps: next-cycle check failed");
`else
`define PPS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/pps_pkg.sv
// Types, constants and the CORDIC arc table for the pure pursuit steering block.
// No dependencies.
package pps_pkg;

	localparam int CORDIC_STEPS = 24;
	localparam int DIV_BITS     = 16;
	localparam int D2W          = 63;   // squared distance, Q39.24
	localparam int XLW          = 38;   // vehicle-frame coordinate
	localparam int NUMW         = 62;   // division numerator
	localparam int IDXW         = 10;   // target_index width

	localparam logic signed [33:0] CORDIC_KINV  = 34'sd652032874;
	localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;
	localparam logic signed [33:0] HALF_TURN    = 34'sd2147483648;
	localparam logic [D2W-1:0]     FAR_D2       = 63'd167772160000000000;

	typedef enum logic [1:0] {
		REG_LOOK_AHEAD = 2'd0,
		REG_GAIN       = 2'd1,
		REG_COUNT      = 2'd2
	} pps_reg_t;

	typedef struct packed {
		logic load_wp;
		logic pose_latch;
		logic cordic_init;
		logic cordic_step;
		logic scan_rd;
		logic div_init;
		logic div_check;
		logic div_step;
		logic res_load;
	} pps_cmd_t;

	typedef struct packed {
		logic pipe_busy;
	} pps_stat_t;

	// Arc tangent of 2^-i in 2^32 units per turn
	function automatic logic [29:0] pps_arc(input logic [4:0] i);
		logic [29:0] a;
		case (i)
			5'd0:  a = 30'd536870912;
			5'd1:  a = 30'd316933406;
			5'd2:  a = 30'd167458907;
			5'd3:  a = 30'd85004756;
			5'd4:  a = 30'd42667331;
			5'd5:  a = 30'd21354465;
			5'd6:  a = 30'd10679838;
			5'd7:  a = 30'd5340245;
			5'd8:  a = 30'd2670163;
			5'd9:  a = 30'd1335087;
			5'd10: a = 30'd667544;
			5'd11: a = 30'd333772;
			5'd12: a = 30'd166886;
			5'd13: a = 30'd83443;
			5'd14: a = 30'd41722;
			5'd15: a = 30'd20861;
			5'd16: a = 30'd10430;
			5'd17: a = 30'd5215;
			5'd18: a = 30'd2608;
			5'd19: a = 30'd1304;
			5'd20: a = 30'd652;
			5'd21: a = 30'd326;
			5'd22: a = 30'd163;
			5'd23: a = 30'd81;
			default: a = 30'd0;
		endcase
		return a;
	endfunction

endpackage

>>> sv/pps_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module pps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write on enable, register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

>>> sv/pps_ctrl.sv
// Sequencer for the pure pursuit steering block: handshakes, CORDIC, scan, divide.
// Depends on pps_pkg and pure_pursuit_steering_defines.svh.
`include "pure_pursuit_steering_defines.svh"
module pps_ctrl #(
	parameter int MAX_WAYPOINTS = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             command,
	input  logic [9:0]                       waypoint_index,
	output logic                             out_valid,
	input  logic                             out_ready,
	input  logic [10:0]                      waypoint_count,
	input  pps_pkg::pps_stat_t               stat,
	output pps_pkg::pps_cmd_t                cmd,
	output logic [4:0]                       ops_idx,
	output logic [$clog2(MAX_WAYPOINTS)-1:0] scan_addr
);

	localparam int AW = $clog2(MAX_WAYPOINTS);
	localparam int CW = $clog2(MAX_WAYPOINTS + 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_CINIT, ST_CSTEP, ST_SCAN, ST_DRAIN,
		ST_DINIT, ST_DCHECK, ST_DSTEP, ST_FINISH
	} state_t;

	state_t        state_q;
	logic [4:0]    ops_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] lim;
	logic          out_valid_q;
	logic          in_range;
	logic          out_free;

	// Clamp the searched count to the table depth
	assign lim = (32'(waypoint_count) > MAX_WAYPOINTS) ? CW'(MAX_WAYPOINTS)
		: CW'(waypoint_count);
	assign in_range = 32'(waypoint_index) < MAX_WAYPOINTS;
	assign out_free = !out_valid_q || out_ready;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign ops_idx   = ops_q;
	assign scan_addr = cnt_q[AW-1:0];

	// Decode commands from state
	always_comb begin
		cmd             = '0;
		cmd.load_wp     = (state_q == ST_IDLE) && in_valid && !command && in_range;
		cmd.pose_latch  = (state_q == ST_IDLE) && in_valid && command;
		cmd.cordic_init = (state_q == ST_CINIT);
		cmd.cordic_step = (state_q == ST_CSTEP);
		cmd.scan_rd     = (state_q == ST_SCAN) && (cnt_q != lim);
		cmd.div_init    = (state_q == ST_DINIT);
		cmd.div_check   = (state_q == ST_DCHECK);
		cmd.div_step    = (state_q == ST_DSTEP);
		cmd.res_load    = (state_q == ST_FINISH) && out_free;
	end

	// Advance the sequence, hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ops_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && command) begin
						state_q <= ST_CINIT;
					end
				end
				ST_CINIT: begin
					ops_q   <= '0;
					state_q <= ST_CSTEP;
				end
				ST_CSTEP: begin
					if (ops_q == 5'(pps_pkg::CORDIC_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_SCAN;
					end else begin
						ops_q <= ops_q + 5'd1;
					end
				end
				ST_SCAN: begin
					if (cnt_q == lim) begin
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_DRAIN: begin
					if (!stat.pipe_busy) begin
						state_q <= ST_DINIT;
					end
				end
				ST_DINIT: begin
					state_q <= ST_DCHECK;
				end
				ST_DCHECK: begin
					ops_q   <= '0;
					state_q <= ST_DSTEP;
				end
				ST_DSTEP: begin
					if (ops_q == 5'(pps_pkg::DIV_BITS - 1)) begin
						state_q <= ST_FINISH;
					end else begin
						ops_q <= ops_q + 5'd1;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`PPS_ASSERT_IMP(a_scan_in_range, clk, arst_n, cmd.scan_rd, cnt_q < lim)
	`PPS_ASSERT_NEXT(a_result_shown, clk, arst_n, cmd.res_load, out_valid_q)
	`PPS_ASSERT_IMP(a_idle_drained, clk, arst_n, state_q == ST_IDLE, !stat.pipe_busy)
	`PPS_ASSERT_NEXT(a_pose_starts, clk, arst_n, cmd.pose_latch, state_q == ST_CINIT)

endmodule

>>> sv/pps_dp.sv
// Datapath: waypoint tables, CORDIC, vehicle-frame scan pipeline, divider.
// Depends on pps_pkg and pps_ram.
module pps_dp #(
	parameter int MAX_WAYPOINTS = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pps_pkg::pps_cmd_t                cmd,
	input  logic [4:0]                       ops_idx,
	input  logic [$clog2(MAX_WAYPOINTS)-1:0] scan_addr,
	input  logic [9:0]                       waypoint_index,
	input  logic signed [31:0]               point_x,
	input  logic signed [31:0]               point_y,
	input  logic signed [15:0]               heading,
	input  logic [30:0]                      look_ahead_distance,
	input  logic [14:0]                      steering_gain,
	output pps_pkg::pps_stat_t               stat,
	output logic signed [15:0]               steering,
	output logic [9:0]                       target_index,
	output logic                             target_found
);

	localparam int AW   = $clog2(MAX_WAYPOINTS);
	localparam int D2W  = pps_pkg::D2W;
	localparam int XLW  = pps_pkg::XLW;
	localparam int NUMW = pps_pkg::NUMW;
	localparam int DENW = D2W + pps_pkg::DIV_BITS - 1;
	localparam logic signed [33:0] QUARTER_TURN_C = pps_pkg::QUARTER_TURN;

	// Pose and look-ahead
	logic signed [31:0] px_q, py_q;
	logic signed [15:0] hd_q;
	logic [53:0]        la2_q;

	// CORDIC
	logic signed [33:0] cx_q, cy_q, cz_q, z0, xs, ys, arc;
	logic               pre;
	logic signed [31:0] cs_c, sn_c;

	// Tables
	logic [AW-1:0]      ram_addr;
	logic [31:0]        rx, ry;

	// Scan pipeline
	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [AW-1:0]      idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;
	logic signed [32:0] dx_s2, dy_s2;
	logic signed [64:0] dxc_s3, dys_s3, dyc_s3, dxs_s3;
	logic signed [65:0] sumx, sumy;
	logic signed [XLW-1:0] xl_s4, yl_s4, yl_s5;
	logic [XLW-1:0]     magx, magy;
	logic [30:0]        ax, ay;
	logic [D2W-1:0]     d2_s5;
	logic               cone_s5, hit;

	// Best candidate
	logic [D2W-1:0]        best_q;
	logic [AW-1:0]         best_i_q;
	logic signed [XLW-1:0] best_y_q;
	logic                  found_q;
	logic [XLW-1:0]        magb;

	// Divider
	logic [NUMW-1:0]    num_q, rem_q;
	logic [DENW-1:0]    den_q;
	logic [15:0]        q_q;
	logic               ovf_q, take;
	logic signed [15:0] steer;

	assign stat.pipe_busy = v_s1 | v_s2 | v_s3 | v_s4 | v_s5;

	// Latch the pose and square the look-ahead distance
	always_ff @(posedge clk) begin
		if (cmd.pose_latch) begin
			px_q <= point_x;
			py_q <= point_y;
			hd_q <= heading;
		end
		if (cmd.cordic_init) begin
			la2_q <= 54'(look_ahead_distance[30:4]) * 54'(look_ahead_distance[30:4]);
		end
	end

	// Rotate the unit vector to the yaw, one step a cycle
	assign z0   = {{2{hd_q[15]}}, hd_q, 16'b0};
	assign pre  = (z0 > QUARTER_TURN_C) || (z0 < -QUARTER_TURN_C);
	assign xs   = cx_q >>> ops_idx;
	assign ys   = cy_q >>> ops_idx;
	assign arc  = $signed({4'b0, pps_pkg::pps_arc(ops_idx)});
	assign cs_c = 32'(cx_q >>> 2);
	assign sn_c = 32'(cy_q >>> 2);

	always_ff @(posedge clk) begin
		if (cmd.cordic_init) begin
			cx_q <= pre ? -pps_pkg::CORDIC_KINV : pps_pkg::CORDIC_KINV;
			cy_q <= '0;
			if (!pre) begin
				cz_q <= z0;
			end else if (z0 > 34'sd0) begin
				cz_q <= z0 - pps_pkg::HALF_TURN;
			end else begin
				cz_q <= z0 + pps_pkg::HALF_TURN;
			end
		end else if (cmd.cordic_step) begin
			if (!cz_q[33]) begin
				cx_q <= cx_q - ys;
				cy_q <= cy_q + xs;
				cz_q <= cz_q - arc;
			end else begin
				cx_q <= cx_q + ys;
				cy_q <= cy_q - xs;
				cz_q <= cz_q + arc;
			end
		end
	end

	// Waypoint tables share one address: load writes, scan reads
	assign ram_addr = cmd.load_wp ? AW'(waypoint_index) : scan_addr;

	pps_ram #(.WIDTH(32), .DEPTH(MAX_WAYPOINTS)) u_ram_x (
		.clk   (clk),
		.we    (cmd.load_wp),
		.addr  (ram_addr),
		.wdata (point_x),
		.rdata (rx)
	);

	pps_ram #(.WIDTH(32), .DEPTH(MAX_WAYPOINTS)) u_ram_y (
		.clk   (clk),
		.we    (cmd.load_wp),
		.addr  (ram_addr),
		.wdata (point_y),
		.rdata (ry)
	);

	// Advance the valid tags of the scan pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= cmd.scan_rd;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	assign sumx = 66'(dxc_s3) + 66'(dys_s3);
	assign sumy = 66'(dyc_s3) - 66'(dxs_s3);
	assign magx = xl_s4[XLW-1] ? XLW'(-xl_s4) : XLW'(xl_s4);
	assign magy = yl_s4[XLW-1] ? XLW'(-yl_s4) : XLW'(yl_s4);
	assign ax   = magx[34:4];
	assign ay   = magy[34:4];

	// Offset, rotate, square
	always_ff @(posedge clk) begin
		idx_s1 <= scan_addr;
		dx_s2  <= 33'(signed'(rx)) - 33'(px_q);
		dy_s2  <= 33'(signed'(ry)) - 33'(py_q);
		idx_s2 <= idx_s1;
		dxc_s3 <= dx_s2 * cs_c;
		dys_s3 <= dy_s2 * sn_c;
		dyc_s3 <= dy_s2 * cs_c;
		dxs_s3 <= dx_s2 * sn_c;
		idx_s3 <= idx_s2;
		xl_s4  <= sumx[65:28];
		yl_s4  <= sumy[65:28];
		idx_s4 <= idx_s3;
		d2_s5   <= D2W'(62'(ax) * 62'(ax)) + D2W'(62'(ay) * 62'(ay));
		cone_s5 <= xl_s4 > $signed({1'b0, magy});
		yl_s5   <= yl_s4;
		idx_s5  <= idx_s4;
	end

	// Keep the nearest qualifying waypoint; lowest index wins a tie
	assign hit = v_s5 && cone_s5 && (d2_s5 >= D2W'(la2_q)) && (d2_s5 < best_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.cordic_init) begin
			found_q <= 1'b0;
		end else if (hit) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cordic_init) begin
			best_q   <= pps_pkg::FAR_D2;
			best_i_q <= '0;
			best_y_q <= '0;
		end else if (hit) begin
			best_q   <= d2_s5;
			best_i_q <= idx_s5;
			best_y_q <= yl_s5;
		end
	end

	// Restoring divide, one quotient bit a cycle
	assign magb = best_y_q[XLW-1] ? XLW'(-best_y_q) : XLW'(best_y_q);
	assign take = {{(DENW-NUMW){1'b0}}, rem_q} >= den_q;

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			num_q <= {53'(steering_gain) * 53'(magb), 9'b0};
			den_q <= {best_q, {(pps_pkg::DIV_BITS-1){1'b0}}};
			q_q   <= '0;
		end else if (cmd.div_check) begin
			ovf_q <= {{(DENW+1-NUMW){1'b0}}, num_q} >= {best_q, {pps_pkg::DIV_BITS{1'b0}}};
			rem_q <= num_q;
		end else if (cmd.div_step) begin
			if (take) begin
				rem_q <= rem_q - den_q[NUMW-1:0];
			end
			q_q   <= {q_q[14:0], take};
			den_q <= den_q >> 1;
		end
	end

	// Sign and saturate
	always_comb begin
		if (!found_q) begin
			steer = '0;
		end else if (best_q == '0) begin
			if (best_y_q > 0) begin
				steer = 16'sd32767;
			end else if (best_y_q < 0) begin
				steer = -16'sd32768;
			end else begin
				steer = '0;
			end
		end else if (best_y_q < 0) begin
			steer = (ovf_q || q_q > 16'd32768) ? -16'sd32768 : signed'(-q_q);
		end else begin
			steer = (ovf_q || q_q > 16'd32767) ? 16'sd32767 : signed'(q_q);
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			steering     <= steer;
			target_index <= found_q ? pps_pkg::IDXW'(best_i_q) : '0;
			target_found <= found_q;
		end
	end

endmodule

>>> sv/pure_pursuit_steering.sv
// Pure pursuit steering: waypoint table plus nearest look-ahead target search.
// Load word: accepted in an idle cycle, no result. Pose word: the scan reads one
// waypoint a cycle from the table RAM, framed by a 24-step CORDIC and a 16-step
// restoring divider. One word is in work at a time; the next is taken in the cycle
// after the result loads.
// arst_n clears control and restores register defaults; the table is not cleared.
module pure_pursuit_steering #(
	parameter int MAX_WAYPOINTS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               command,
	input  logic [9:0]         waypoint_index,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [15:0] heading,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] steering,
	output logic [9:0]         target_index,
	output logic               target_found,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [30:0]        cfg_data
);

	localparam int AW = $clog2(MAX_WAYPOINTS);

	logic [30:0] lad_q;
	logic [14:0] gain_q;
	logic [10:0] wcount_q;

	pps_pkg::pps_cmd_t  cmd;
	pps_pkg::pps_stat_t stat;
	logic [4:0]         ops_idx;
	logic [AW-1:0]      scan_addr;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lad_q    <= 31'd81920;
			gain_q   <= 15'd2253;
			wcount_q <= 11'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pps_pkg::REG_LOOK_AHEAD: lad_q    <= cfg_data;
				pps_pkg::REG_GAIN:       gain_q   <= cfg_data[14:0];
				pps_pkg::REG_COUNT:      wcount_q <= cfg_data[10:0];
				default: begin
					// drop writes beyond the register list
				end
			endcase
		end
	end

	pps_ctrl #(.MAX_WAYPOINTS(MAX_WAYPOINTS)) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.waypoint_index (waypoint_index),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.waypoint_count (wcount_q),
		.stat           (stat),
		.cmd            (cmd),
		.ops_idx        (ops_idx),
		.scan_addr      (scan_addr)
	);

	pps_dp #(.MAX_WAYPOINTS(MAX_WAYPOINTS)) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.ops_idx             (ops_idx),
		.scan_addr           (scan_addr),
		.waypoint_index      (waypoint_index),
		.point_x             (point_x),
		.point_y             (point_y),
		.heading             (heading),
		.look_ahead_distance (lad_q),
		.steering_gain       (gain_q),
		.stat                (stat),
		.steering            (steering),
		.target_index        (target_index),
		.target_found        (target_found)
	);

endmodule
